// ===== hw/rtl/mtt_pkg.sv =====
// Shared types and codes for the multi timer table.
package mtt_pkg;

  localparam int TIMERS_DEF = 16;

  localparam int NOW_W    = 48;
  localparam int PERIOD_W = 32;
  localparam int ID_W     = 32;

  localparam logic [1:0] OP_SET    = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_TICK   = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam logic KIND_REPLY = 1'b0;
  localparam logic KIND_FIRE  = 1'b1;

  typedef struct packed {
    logic [ID_W-1:0]     ident;
    logic [PERIOD_W-1:0] period;
    logic [NOW_W-1:0]    accum;
    logic [NOW_W-1:0]    sample_time;
    logic                reload;
    logic                active;
  } entry_t;

endpackage

// ===== hw/rtl/mtt_cell.sv =====
// One timer slot of the chain: holds, takes its neighbor, or loads a new entry.
module mtt_cell
  import mtt_pkg::*;
(
  input  logic   clk,
  input  logic   shift_en,
  input  logic   load_en,
  input  entry_t nb_data,
  input  entry_t load_data,
  output entry_t slot_q
);

  entry_t slot_r;
  entry_t slot_nxt;

  // load wins over the shift so the tail of the queue gets the new entry
  always_comb begin
    slot_nxt = slot_r;
    if (load_en) begin
      slot_nxt = load_data;
    end else if (shift_en) begin
      slot_nxt = nb_data;
    end
  end

  always_ff @(posedge clk) begin
    slot_r <= slot_nxt;
  end

  assign slot_q = slot_r;

endmodule

// ===== hw/rtl/multi_timer_table_top.sv =====
// Top level of the multi timer table: command control and the chain of slots.
//
// Usage: present an operation on the in_ ports with start high; it is taken
// at a clock edge where busy is low. Results appear on the out_ ports for one
// cycle each, marked by out_valid; out_last marks the final result of a
// command. The receiver cannot stall, so results are never held back.
// Command flow:
//   set with id 0: the reply shows the cycle after the transfer.
//   set or remove with an id: the chain rotates once through the head of
//   the chain, where the id compare is done.
//   tick: each slot goes through the elapsed-time add in TICK_A and then the
//   period compare and reload in TICK_B; a flush step follows when a timer fired.
//   Fires leave in table order; each is held until the next slot fires or
//   the walk ends, so the final one can be marked last.
// The slots form a queue: each scan or TICK_B step pops the head, updates it
// and pushes it at the tail unless it drops out, so the table stays compact
// and ordered. Reset empties the table and restarts id numbering at one; slot
// contents are not cleared.
module multi_timer_table_top
  import mtt_pkg::*;
#(
  parameter int TIMERS = TIMERS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          in_operation,
  input  logic [NOW_W-1:0]    in_now,
  input  logic [PERIOD_W-1:0] in_period,
  input  logic                in_repeating,
  input  logic [ID_W-1:0]     in_timer_id,
  output logic                out_valid,
  output logic                out_kind,
  output logic [ID_W-1:0]     out_result_id,
  output logic                out_last
);

  localparam int CW = $clog2(TIMERS + 1);
  localparam int IW = (TIMERS > 1) ? $clog2(TIMERS) : 1;
  localparam logic [CW-1:0] FULL = CW'(TIMERS);
  localparam logic [CW-1:0] ONE  = CW'(1);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_SCAN   = 5'b00010,
    ST_TICK_A = 5'b00100,
    ST_TICK_B = 5'b01000,
    ST_FLUSH  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic [1:0]          op_r, op_nxt;
  logic [NOW_W-1:0]    now_r, now_nxt;
  logic [PERIOD_W-1:0] per_r, per_nxt;
  logic                rep_r, rep_nxt;
  logic [ID_W-1:0]     id_r, id_nxt;
  logic [CW-1:0]       cnt_r, cnt_nxt;
  logic [CW-1:0]       rem_r, rem_nxt;
  logic                found_r, found_nxt;
  logic [NOW_W-1:0]    acc_r, acc_nxt;
  logic                pend_v_r, pend_v_nxt;
  logic [ID_W-1:0]     pend_id_r, pend_id_nxt;
  logic [ID_W-1:0]     nid_r, nid_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                out_kind_r, out_kind_nxt;
  logic [ID_W-1:0]     out_id_r, out_id_nxt;
  logic                out_last_r, out_last_nxt;

  logic          shift_en;
  logic          wr_en;
  logic [IW-1:0] wr_pos;
  entry_t        wr_data;
  entry_t        slots [TIMERS];
  entry_t        head;
  entry_t        upd;
  logic [CW-1:0] tail_pos;
  logic [NOW_W-1:0] delta;
  logic [NOW_W:0]   sum;
  logic          hit;
  logic          fire;
  logic [ID_W-1:0] nid_inc;

  assign head     = slots[0];
  assign tail_pos = cnt_r - ONE;
  assign delta    = now_r - head.sample_time;
  assign sum      = {1'b0, head.accum} + {1'b0, delta};
  assign hit      = !found_r && (head.ident == id_r);
  assign fire     = head.active && (acc_r >= {{(NOW_W-PERIOD_W){1'b0}}, head.period});
  assign nid_inc  = nid_r + ID_W'(1);

  // build the chain; the last cell takes itself as a neighbor
  for (genvar i = 0; i < TIMERS; i++) begin : g_cell
    entry_t nb;
    if (i == TIMERS - 1) begin : g_end
      assign nb = slots[i];
    end else begin : g_mid
      assign nb = slots[i+1];
    end
    mtt_cell u_cell (
      .clk       (clk),
      .shift_en  (shift_en),
      .load_en   (wr_en && (wr_pos == IW'(i))),
      .nb_data   (nb),
      .load_data (wr_data),
      .slot_q    (slots[i])
    );
  end

  // command sequencer
  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    now_nxt       = now_r;
    per_nxt       = per_r;
    rep_nxt       = rep_r;
    id_nxt        = id_r;
    cnt_nxt       = cnt_r;
    rem_nxt       = rem_r;
    found_nxt     = found_r;
    acc_nxt       = acc_r;
    pend_v_nxt    = pend_v_r;
    pend_id_nxt   = pend_id_r;
    nid_nxt       = nid_r;
    out_valid_nxt = 1'b0;
    out_kind_nxt  = out_kind_r;
    out_id_nxt    = out_id_r;
    out_last_nxt  = out_last_r;
    shift_en      = 1'b0;
    wr_en         = 1'b0;
    wr_pos        = tail_pos[IW-1:0];
    wr_data       = head;
    upd           = head;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          op_nxt    = in_operation;
          now_nxt   = in_now;
          per_nxt   = in_period;
          rep_nxt   = in_repeating;
          id_nxt    = in_timer_id;
          rem_nxt   = cnt_r;
          found_nxt = 1'b0;
          case (in_operation)
            OP_SET: begin
              out_valid_nxt = 1'b1;
              out_kind_nxt  = KIND_REPLY;
              out_last_nxt  = 1'b1;
              out_id_nxt    = '0;
              if (in_timer_id == '0) begin
                if (cnt_r != FULL) begin
                  // append a new timer at the tail
                  wr_en               = 1'b1;
                  wr_pos              = cnt_r[IW-1:0];
                  wr_data.ident       = nid_r;
                  wr_data.period      = in_period;
                  wr_data.accum       = '0;
                  wr_data.sample_time = in_now;
                  wr_data.reload      = in_repeating;
                  wr_data.active      = 1'b1;
                  out_id_nxt          = nid_r;
                  cnt_nxt             = cnt_r + ONE;
                  nid_nxt             = (nid_inc == '0) ? ID_W'(1) : nid_inc;
                end
              end else if (cnt_r != '0) begin
                out_valid_nxt = 1'b0;
                state_nxt     = ST_SCAN;
              end
            end
            OP_REMOVE: begin
              if (cnt_r != '0) begin
                state_nxt = ST_SCAN;
              end
            end
            OP_TICK: begin
              if (cnt_r != '0) begin
                pend_v_nxt = 1'b0;
                state_nxt  = ST_TICK_A;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_SCAN: begin
        // rotate the queue once, patching the first matching id
        if (hit) begin
          if (op_r == OP_SET) begin
            upd.period      = per_r;
            upd.reload      = rep_r;
            upd.sample_time = now_r;
            upd.active      = 1'b1;
            upd.accum       = '0;
          end else begin
            upd.active = 1'b0;
          end
        end
        shift_en  = 1'b1;
        wr_en     = 1'b1;
        wr_data   = upd;
        found_nxt = found_r || hit;
        rem_nxt   = rem_r - ONE;
        if (rem_r == ONE) begin
          state_nxt = ST_IDLE;
          if (op_r == OP_SET) begin
            out_valid_nxt = 1'b1;
            out_kind_nxt  = KIND_REPLY;
            out_last_nxt  = 1'b1;
            out_id_nxt    = (found_r || hit) ? id_r : '0;
          end
        end
      end
      ST_TICK_A: begin
        // accumulate elapsed time, saturating
        acc_nxt   = sum[NOW_W] ? {NOW_W{1'b1}} : sum[NOW_W-1:0];
        state_nxt = ST_TICK_B;
      end
      ST_TICK_B: begin
        // compare, reload or retire, then push or drop the head
        if (head.active) begin
          upd.sample_time = now_r;
          upd.accum = (fire && head.reload) ?
                      (acc_r - {{(NOW_W-PERIOD_W){1'b0}}, head.period}) : acc_r;
          if (fire && !head.reload) begin
            upd.active = 1'b0;
          end
        end
        shift_en = 1'b1;
        wr_data  = upd;
        if (upd.active) begin
          wr_en = 1'b1;
        end else begin
          cnt_nxt = cnt_r - ONE;
        end
        if (fire) begin
          if (pend_v_r) begin
            out_valid_nxt = 1'b1;
            out_kind_nxt  = KIND_FIRE;
            out_last_nxt  = 1'b0;
            out_id_nxt    = pend_id_r;
          end
          pend_v_nxt  = 1'b1;
          pend_id_nxt = head.ident;
        end
        rem_nxt = rem_r - ONE;
        if (rem_r == ONE) begin
          state_nxt = (pend_v_r || fire) ? ST_FLUSH : ST_IDLE;
        end else begin
          state_nxt = ST_TICK_A;
        end
      end
      ST_FLUSH: begin
        // send the held fire as the final result
        out_valid_nxt = 1'b1;
        out_kind_nxt  = KIND_FIRE;
        out_last_nxt  = 1'b1;
        out_id_nxt    = pend_id_r;
        pend_v_nxt    = 1'b0;
        state_nxt     = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      rem_r       <= '0;
      found_r     <= 1'b0;
      pend_v_r    <= 1'b0;
      nid_r       <= ID_W'(1);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      rem_r       <= rem_nxt;
      found_r     <= found_nxt;
      pend_v_r    <= pend_v_nxt;
      nid_r       <= nid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    now_r      <= now_nxt;
    per_r      <= per_nxt;
    rep_r      <= rep_nxt;
    id_r       <= id_nxt;
    acc_r      <= acc_nxt;
    pend_id_r  <= pend_id_nxt;
    out_kind_r <= out_kind_nxt;
    out_id_r   <= out_id_nxt;
    out_last_r <= out_last_nxt;
  end

  assign busy          = (state_r != ST_IDLE);
  assign out_valid     = out_valid_r;
  assign out_kind      = out_kind_r;
  assign out_result_id = out_id_r;
  assign out_last      = out_last_r;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= FULL) else $error("timer count above table size");
  a_tick_enter: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_operation == OP_TICK && cnt_r != '0) |=> state_r == ST_TICK_A)
    else $error("tick did not start the walk");
  a_reply_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind == KIND_REPLY) |-> out_last) else $error("set reply not last");
  a_flush_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FLUSH) |=> (out_valid && out_last && out_kind == KIND_FIRE))
    else $error("held fire not sent as final result");
`endif

endmodule
